>>> src/rdvl_pkg.sv
// Package for the row deletion visibility log: constants, payload types and state codes.
// No dependencies.
`timescale 1ns / 1ps
package rdvl_pkg;
    localparam int BLOCK_ENTRIES = 64;
    localparam int LOG_DEPTH = 1024;
    localparam int NWORDS = 4;
    localparam int STAMP_W = 56;
    localparam int ROW_W = 8;
    localparam int ENTRY_W = ROW_W + STAMP_W;
    localparam int PTR_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int BLK_W = $clog2(BLOCK_ENTRIES) + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] OP_DELETE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_COLLECT = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_OLD = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STAMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS3 = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic [ROW_W-1:0]   row_id;
        logic [STAMP_W-1:0] stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  word_index;
        logic [63:0] bitmap_word;
        logic        last_word;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAIL_RD,
        S_TAIL_WAIT,
        S_Q_RD,
        S_Q_CHK,
        S_C_RD,
        S_C_CHK,
        S_F_RD,
        S_F_CHK,
        S_EMIT
    } state_t;
endpackage

>>> src/rdvl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rdvl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/row_delete_visibility_log_unit.sv
// Row deletion visibility log: 256-row deletion tracker with a base bitmap and a ring log.
// Uses rdvl_pkg and rdvl_ram.
// Delete reads the newest log entry, if any, before it appends; query and collect walk the
// log through the log RAM read port, query with a read and a check state per entry, collect
// by checking the last entry of each block of up to 64 entries and then folding entries one
// by one. Results leave through an output register, up to four per item. One
// item is worked on at a time. Reset clears the base, the query words and the log pointers;
// log contents are left undefined.
`timescale 1ns / 1ps
module row_delete_visibility_log_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  rdvl_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output rdvl_pkg::out_item_t          out_data,
    input  logic                         cfg_we,
    input  logic [rdvl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdvl_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int PW = rdvl_pkg::PTR_W;
    localparam int CW = rdvl_pkg::CNT_W;
    localparam int SW = rdvl_pkg::STAMP_W;

    rdvl_pkg::state_t state_reg, state_next;

    logic [SW-1:0] cfg_stamp_reg;
    logic [63:0]   cfg_bits_reg [rdvl_pkg::NWORDS];
    logic [63:0]   base_bits_reg [rdvl_pkg::NWORDS], base_bits_next [rdvl_pkg::NWORDS];
    logic [63:0]   acc_reg [rdvl_pkg::NWORDS], acc_next [rdvl_pkg::NWORDS];
    logic [SW-1:0] base_stamp_reg, base_stamp_next;
    logic [PW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    rdvl_pkg::in_item_t item_reg, item_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] freed_reg, freed_next;
    logic [SW-1:0] nb_reg, nb_next;
    logic [1:0]    status_reg, status_next;
    logic          multi_reg, multi_next;
    logic [1:0]    widx_reg, widx_next;
    logic          ov_reg, ov_next;
    rdvl_pkg::out_item_t od_reg, od_next;

    logic          ram_we;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [rdvl_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [SW-1:0] rd_stamp;
    logic [7:0]    rd_row;
    logic [CW-1:0] blk_end;

    rdvl_ram #(.WIDTH(rdvl_pkg::ENTRY_W), .DEPTH(rdvl_pkg::LOG_DEPTH)) u_log (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign rd_stamp = ram_rdata[SW-1:0];
    assign rd_row = ram_rdata[rdvl_pkg::ENTRY_W-1:SW];
    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign in_stall = (state_reg != rdvl_pkg::S_IDLE) || ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdvl_pkg::S_IDLE;
            cfg_stamp_reg <= '0;
            base_stamp_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            ov_reg <= 1'b0;
            for (int k = 0; k < rdvl_pkg::NWORDS; k++)
            begin
                cfg_bits_reg[k] <= '0;
                base_bits_reg[k] <= '0;
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            base_stamp_reg <= base_stamp_next;
            head_reg <= head_next;
            count_reg <= count_next;
            ov_reg <= ov_next;
            for (int k = 0; k < rdvl_pkg::NWORDS; k++)
            begin
                base_bits_reg[k] <= base_bits_next[k];
                acc_reg[k] <= acc_next[k];
            end
            if (cfg_we)
            begin
                if (cfg_index == rdvl_pkg::CFG_STAMP)
                begin
                    cfg_stamp_reg <= cfg_data[SW-1:0];
                end
                else if (cfg_index <= rdvl_pkg::CFG_BITS3)
                begin
                    cfg_bits_reg[2'(cfg_index - rdvl_pkg::CFG_BITS0)] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg <= idx_next;
        freed_reg <= freed_next;
        nb_reg <= nb_next;
        status_reg <= status_next;
        multi_reg <= multi_next;
        widx_reg <= widx_next;
        od_reg <= od_next;
    end

    always_comb
    begin
        logic [CW-1:0] rem;
        state_next = state_reg;
        base_stamp_next = base_stamp_reg;
        head_next = head_reg;
        count_next = count_reg;
        item_next = item_reg;
        idx_next = idx_reg;
        freed_next = freed_reg;
        nb_next = nb_reg;
        status_next = status_reg;
        multi_next = multi_reg;
        widx_next = widx_reg;
        ov_next = ov_reg && out_stall;
        od_next = od_reg;
        for (int k = 0; k < rdvl_pkg::NWORDS; k++)
        begin
            base_bits_next[k] = base_bits_reg[k];
            acc_next[k] = acc_reg[k];
        end
        ram_we = 1'b0;
        ram_waddr = PW'(head_reg + count_reg[PW-1:0]);
        ram_wdata = {item_reg.row_id, item_reg.stamp};
        ram_raddr = PW'(head_reg + idx_reg[PW-1:0]);
        rem = count_reg - idx_reg;
        blk_end = (rem > CW'(rdvl_pkg::BLOCK_ENTRIES)) ?
                  idx_reg + CW'(rdvl_pkg::BLOCK_ENTRIES) : count_reg;

        unique case (state_reg)
            rdvl_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    item_next = in_data;
                    status_next = rdvl_pkg::ST_OK;
                    multi_next = 1'b0;
                    widx_next = 2'd0;
                    idx_next = '0;
                    freed_next = '0;
                    nb_next = base_stamp_reg;
                    if (in_data.operation == rdvl_pkg::OP_RESTART)
                    begin
                        base_stamp_next = cfg_stamp_reg;
                        for (int k = 0; k < rdvl_pkg::NWORDS; k++)
                        begin
                            base_bits_next[k] = cfg_bits_reg[k];
                        end
                        head_next = '0;
                        count_next = '0;
                        state_next = rdvl_pkg::S_EMIT;
                    end
                    else if (in_data.stamp < base_stamp_reg)
                    begin
                        status_next = rdvl_pkg::ST_TOO_OLD;
                        state_next = rdvl_pkg::S_EMIT;
                    end
                    else if (in_data.operation == rdvl_pkg::OP_DELETE)
                    begin
                        if (count_reg == '0)
                        begin
                            ram_we = 1'b1;
                            ram_wdata = {in_data.row_id, in_data.stamp};
                            count_next = count_reg + 1'b1;
                            state_next = rdvl_pkg::S_EMIT;
                        end
                        else
                        begin
                            idx_next = count_reg - 1'b1;
                            state_next = rdvl_pkg::S_TAIL_RD;
                        end
                    end
                    else if (in_data.operation == rdvl_pkg::OP_QUERY)
                    begin
                        multi_next = 1'b1;
                        for (int k = 0; k < rdvl_pkg::NWORDS; k++)
                        begin
                            acc_next[k] = base_bits_reg[k];
                        end
                        state_next = (in_data.stamp == base_stamp_reg || count_reg == '0) ?
                                     rdvl_pkg::S_EMIT : rdvl_pkg::S_Q_RD;
                    end
                    else
                    begin
                        state_next = (in_data.stamp == base_stamp_reg || count_reg == '0) ?
                                     rdvl_pkg::S_EMIT : rdvl_pkg::S_C_RD;
                    end
                end
            end
            rdvl_pkg::S_TAIL_RD:
            begin
                state_next = rdvl_pkg::S_TAIL_WAIT;
            end
            rdvl_pkg::S_TAIL_WAIT:
            begin
                if (item_reg.stamp < rd_stamp)
                begin
                    status_next = rdvl_pkg::ST_TOO_OLD;
                end
                else if (count_reg >= CW'(rdvl_pkg::LOG_DEPTH))
                begin
                    status_next = rdvl_pkg::ST_FULL;
                end
                else
                begin
                    ram_we = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = rdvl_pkg::S_EMIT;
            end
            rdvl_pkg::S_Q_RD:
            begin
                state_next = rdvl_pkg::S_Q_CHK;
            end
            rdvl_pkg::S_Q_CHK:
            begin
                if (rd_stamp > item_reg.stamp)
                begin
                    state_next = rdvl_pkg::S_EMIT;
                end
                else
                begin
                    acc_next[rd_row[7:6]] = acc_reg[rd_row[7:6]] | (64'd1 << rd_row[5:0]);
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == count_reg) ?
                                 rdvl_pkg::S_EMIT : rdvl_pkg::S_Q_RD;
                end
            end
            rdvl_pkg::S_C_RD:
            begin
                // Read the last entry of the block starting at idx.
                ram_raddr = PW'(head_reg + blk_end[PW-1:0] - 1'b1);
                idx_next = blk_end;
                state_next = rdvl_pkg::S_C_CHK;
            end
            rdvl_pkg::S_C_CHK:
            begin
                if (rd_stamp > item_reg.stamp)
                begin
                    idx_next = '0;
                    state_next = (freed_reg == '0) ? rdvl_pkg::S_EMIT : rdvl_pkg::S_F_RD;
                end
                else
                begin
                    freed_next = idx_reg;
                    nb_next = rd_stamp;
                    if (idx_reg == count_reg)
                    begin
                        idx_next = '0;
                        state_next = rdvl_pkg::S_F_RD;
                    end
                    else
                    begin
                        state_next = rdvl_pkg::S_C_RD;
                    end
                end
            end
            rdvl_pkg::S_F_RD:
            begin
                state_next = rdvl_pkg::S_F_CHK;
            end
            rdvl_pkg::S_F_CHK:
            begin
                // Fold every entry up to the new base time; stops at the first later one.
                if (rd_stamp > nb_reg || idx_reg == count_reg)
                begin
                    base_stamp_next = nb_reg;
                    head_next = PW'(head_reg + freed_reg[PW-1:0]);
                    count_next = count_reg - freed_reg;
                    state_next = rdvl_pkg::S_EMIT;
                end
                else
                begin
                    base_bits_next[rd_row[7:6]] =
                        base_bits_reg[rd_row[7:6]] | (64'd1 << rd_row[5:0]);
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        base_stamp_next = nb_reg;
                        head_next = PW'(head_reg + freed_reg[PW-1:0]);
                        count_next = count_reg - freed_reg;
                        state_next = rdvl_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = rdvl_pkg::S_F_RD;
                    end
                end
            end
            rdvl_pkg::S_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    od_next.status = status_reg;
                    od_next.word_index = widx_reg;
                    od_next.bitmap_word = multi_reg ? acc_reg[widx_reg] : 64'd0;
                    od_next.last_word = !multi_reg || (widx_reg == 2'd3);
                    widx_next = widx_reg + 1'b1;
                    if (!multi_reg || widx_reg == 2'd3)
                    begin
                        state_next = rdvl_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rdvl_pkg::S_IDLE;
            end
        endcase
    end
endmodule
